>>> sv/sparse_polynomial_alu_core_assert.svh
// Assertion macros for the sparse polynomial ALU core.
`ifndef SPARSE_POLYNOMIAL_ALU_CORE_ASSERT_SVH
`define SPARSE_POLYNOMIAL_ALU_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define SPALU_ASSERT_IMPL(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("sparse polynomial alu check failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define SPALU_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("sparse polynomial alu check failed");

`endif

>>> sv/spalu_pkg.sv
// Shared types and constants of the sparse polynomial ALU.
`timescale 1ns / 1ps
package spalu_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int COEF_FRAC_DEF = 16;
  localparam int OUT_LIMIT     = 32;
  localparam int COEF_W        = 32;
  localparam int EXP_W         = 16;
  localparam int TERM_W        = COEF_W + EXP_W;

  typedef enum logic [2:0] {
    KIND_CLR_RES = 3'd0,
    KIND_CLR_OP  = 3'd1,
    KIND_LOAD    = 3'd2,
    KIND_ACC     = 3'd3,
    KIND_MAC     = 3'd4,
    KIND_READ    = 3'd5
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_INS_BEGIN, S_SCAN_TEST, S_SCAN_RD, S_SCAN_CMP,
    S_DEL_TEST, S_DEL_RD, S_DEL_WR, S_PLACE, S_SHIFT_TEST, S_SHIFT_RD,
    S_SHIFT_WR, S_MAC_TEST, S_MAC_RD, S_MAC_MUL, S_MAC_NEG, S_MAC_RND,
    S_MAC_CHK, S_MAC_NEXT, S_RO_RD, S_RO_LD, S_RO_EMPTY
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_CLR_RES, OP_CLR_OP, OP_SETUP_LOAD, OP_SETUP_ACC,
    OP_MAC_INIT, OP_MAC_RD, OP_MAC_MUL, OP_MAC_NEG, OP_MAC_RND, OP_MAC_NEXT,
    OP_SCAN_INIT, OP_SCAN_RD, OP_SCAN_STEP, OP_MERGE, OP_DEL_RD, OP_DEL_WR,
    OP_DEL_DONE, OP_FULL, OP_INS_INIT, OP_INS_RD, OP_INS_WR, OP_INS_PUT,
    OP_RO_INIT, OP_RO_LD, OP_RO_EMPTY
  } dp_op_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       is_mac;
    logic       i_lt_cnt;
    logic       ex_gt;
    logic       ex_eq;
    logic       sum_zero;
    logic       del_more;
    logic       full;
    logic       ins_more;
    logic       ins_zero;
    logic       mac_more;
    logic       mac_skip;
    logic       res_empty;
    logic       out_free;
    logic       ro_last;
  } dp_status_t;

endpackage

>>> sv/sparse_polynomial_alu_core.sv
// Top level of the sparse polynomial ALU: controller, datapath and checks.
`timescale 1ns / 1ps
// The block keeps two sparse polynomials, an operand table and a result
// table, each sorted by descending exponent, in one shared RAM. Commands
// arrive as items on the in_ stream; the item kind selects clear result,
// clear operand, load operand term, accumulate, multiply-accumulate or read
// out. Only read-out produces items on the out_ stream: one per result term,
// at most 32, in descending exponent order with tlast on the final one, or a single
// item flagged empty when the result is zero.
// The block works on one item at a time; in_tready is high only while the
// controller is idle. A table insertion scans for the insert point, merges
// a term of equal exponent and deletes the entry if the sum is zero, else
// shifts the lower entries down to place it, or sets overflow when full;
// every table access goes through the single RAM read port with a
// registered read. A multiply-accumulate inserts one product per operand
// term, skipping products that round to zero or have an exponent out of range.
// A read-out reads each result term from the RAM into the output register.
// The last output item sits in an output register, so the next command item
// is taken while it waits. A stalled receiver holds a read-out in place
// until it takes each item. Reset empties both tables and clears the
// sticky overflow flag at once; the RAM contents need no clearing.
module sparse_polynomial_alu_core import spalu_pkg::*; #(
  parameter int MAX_TERMS      = MAX_TERMS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] term_coefficient, [47:32] term_exponent
  input  logic [3:0]  in_tuser,   // [2:0] kind, [3] negate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] out_coefficient, [47:32] out_exponent
  output logic        out_tlast,
  output logic [1:0]  out_tuser   // [0] empty_res, [1] overflow
);

`include "sparse_polynomial_alu_core_assert.svh"

  dp_op_t     cmd;
  dp_status_t st;

  spalu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  spalu_datapath #(
    .MAX_TERMS     (MAX_TERMS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .st        (st),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // The controller leaves idle right after taking an item.
  `SPALU_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // An empty read-out is a single zero item that closes the run.
  `SPALU_ASSERT_IMPL(a_empty_item, out_tvalid && out_tuser[0], out_tlast && out_tdata == 48'd0)
  // A clear-result item leaves an empty result table when the block is idle again.
  `SPALU_ASSERT_NEXT(a_clear_result, in_tvalid && in_tready && in_tuser[2:0] == KIND_CLR_RES, ##1 (st.res_empty && in_tready))

endmodule

>>> sv/spalu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module spalu_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/spalu_datapath.sv
// Datapath of the sparse polynomial ALU: term tables, counters, arithmetic, output register.
`timescale 1ns / 1ps
module spalu_datapath import spalu_pkg::*; #(
  parameter int MAX_TERMS      = MAX_TERMS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [47:0]       in_tdata,
  input  logic [3:0]        in_tuser,
  input  dp_op_t            cmd,
  output dp_status_t        st,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,
  output logic              out_tlast,
  output logic [1:0]        out_tuser
);

  localparam int CW        = $clog2(MAX_TERMS + 1);
  localparam int IW        = $clog2(MAX_TERMS);
  localparam int AW        = IW + 1;
  localparam int RAM_DEPTH = 2 * (1 << IW);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_TERMS);
  localparam logic [CW:0]   LIM_C = (CW + 1)'(OUT_LIMIT);
  localparam logic signed [63:0] HALF = (COEF_FRAC_BITS == 0) ? 64'sd0 :
    (64'sd1 <<< ((COEF_FRAC_BITS == 0) ? 0 : COEF_FRAC_BITS - 1));

  logic [2:0]          kind_r;
  logic                neg_r;
  logic signed [31:0]  coef_r;
  logic signed [15:0]  exp_r;
  logic [CW-1:0]       opcnt_r, rescnt_r, i_r, j_r, k_r;
  logic                tsel_r;
  logic signed [31:0]  insc_r;
  logic signed [15:0]  inse_r;
  logic signed [63:0]  prod_r;
  logic signed [16:0]  pe_r;
  logic                skip_r;
  logic                sticky_r;
  logic                out_valid_r;
  logic [47:0]         out_data_r;
  logic                out_last_r, out_empty_r, out_ovf_r;

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [TERM_W-1:0]   wdata, rdata;

  logic signed [31:0]  rcoef;
  logic signed [15:0]  rexp;
  logic [CW-1:0]       cnt_sel, jp1, jm1;
  logic signed [32:0]  sum33, acc33;
  logic [31:0]         sum_val, acc_val;
  logic                sum_sat, acc_sat;
  logic signed [63:0]  q64;
  logic [31:0]         rnd_val;
  logic                rnd_sat, rnd_zero, pe_oob;
  logic                out_free;
  logic                out_load;

  assign rcoef   = $signed(rdata[31:0]);
  assign rexp    = $signed(rdata[47:32]);
  assign cnt_sel = tsel_r ? rescnt_r : opcnt_r;
  assign jp1     = j_r + 1'b1;
  assign jm1     = j_r - 1'b1;

  // Merge sum and accumulate negation, both saturated to 32 bits.
  assign sum33 = {rcoef[31], rcoef} + {insc_r[31], insc_r};
  assign sum_sat = sum33[32] != sum33[31];
  assign sum_val = sum_sat ? (sum33[32] ? 32'h8000_0000 : 32'h7fff_ffff) : sum33[31:0];

  assign acc33 = neg_r ? -{coef_r[31], coef_r} : {coef_r[31], coef_r};
  assign acc_sat = acc33[32] != acc33[31];
  assign acc_val = acc_sat ? (acc33[32] ? 32'h8000_0000 : 32'h7fff_ffff) : acc33[31:0];

  // Round half up, then saturate the product.
  assign q64      = (prod_r + HALF) >>> COEF_FRAC_BITS;
  assign rnd_sat  = !((&q64[63:31]) || !(|q64[63:31]));
  assign rnd_val  = rnd_sat ? (q64[63] ? 32'h8000_0000 : 32'h7fff_ffff) : q64[31:0];
  assign rnd_zero = rnd_val == 32'd0;
  assign pe_oob   = pe_r[16] != pe_r[15];

  assign out_free = !out_valid_r || out_tready;
  assign out_load = (cmd == OP_RO_LD) || (cmd == OP_RO_EMPTY);

  always_comb begin
    we    = 1'b0;
    waddr = {tsel_r, i_r[IW-1:0]};
    wdata = {inse_r, insc_r};
    raddr = {tsel_r, i_r[IW-1:0]};
    unique case (cmd)
      OP_MAC_RD: raddr = {1'b0, k_r[IW-1:0]};
      OP_DEL_RD: raddr = {tsel_r, jp1[IW-1:0]};
      OP_INS_RD: raddr = {tsel_r, jm1[IW-1:0]};
      OP_MERGE: begin
        we    = !(sum_val == 32'd0);
        wdata = {inse_r, sum_val};
      end
      OP_DEL_WR, OP_INS_WR: begin
        we    = 1'b1;
        waddr = {tsel_r, j_r[IW-1:0]};
        wdata = rdata;
      end
      OP_INS_PUT: we = 1'b1;
      default: ;
    endcase
  end

  spalu_ram #(
    .WIDTH(TERM_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Control state: counts, sticky flag and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opcnt_r     <= '0;
      rescnt_r    <= '0;
      sticky_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd)
        OP_CLR_RES: begin
          rescnt_r <= '0;
          sticky_r <= 1'b0;
        end
        OP_CLR_OP:    opcnt_r <= '0;
        OP_SETUP_ACC: sticky_r <= sticky_r | acc_sat;
        OP_MAC_RND:   sticky_r <= sticky_r | rnd_sat | (!rnd_zero && pe_oob);
        OP_MERGE:     sticky_r <= sticky_r | sum_sat;
        OP_FULL:      sticky_r <= 1'b1;
        OP_DEL_DONE: begin
          if (tsel_r) rescnt_r <= rescnt_r - 1'b1;
          else        opcnt_r  <= opcnt_r - 1'b1;
        end
        OP_INS_PUT: begin
          if (tsel_r) rescnt_r <= rescnt_r + 1'b1;
          else        opcnt_r  <= opcnt_r + 1'b1;
        end
        OP_RO_LD, OP_RO_EMPTY: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    unique case (cmd)
      OP_ACCEPT: begin
        kind_r <= in_tuser[2:0];
        neg_r  <= in_tuser[3];
        coef_r <= $signed(in_tdata[31:0]);
        exp_r  <= $signed(in_tdata[47:32]);
      end
      OP_SETUP_LOAD: begin
        tsel_r <= 1'b0;
        insc_r <= coef_r;
        inse_r <= exp_r;
      end
      OP_SETUP_ACC: begin
        tsel_r <= 1'b1;
        insc_r <= $signed(acc_val);
        inse_r <= exp_r;
      end
      OP_MAC_INIT: begin
        tsel_r <= 1'b1;
        k_r    <= '0;
      end
      OP_MAC_MUL: begin
        prod_r <= coef_r * rcoef;
        pe_r   <= {exp_r[15], exp_r} + {rexp[15], rexp};
      end
      OP_MAC_NEG: begin
        if (neg_r) prod_r <= -prod_r;
      end
      OP_MAC_RND: begin
        insc_r <= $signed(rnd_val);
        inse_r <= pe_r[15:0];
        skip_r <= rnd_zero || pe_oob;
      end
      OP_MAC_NEXT:  k_r <= k_r + 1'b1;
      OP_SCAN_INIT: i_r <= '0;
      OP_SCAN_STEP: i_r <= i_r + 1'b1;
      OP_MERGE:     j_r <= i_r;
      OP_DEL_WR:    j_r <= jp1;
      OP_INS_INIT:  j_r <= cnt_sel;
      OP_INS_WR:    j_r <= jm1;
      OP_RO_INIT: begin
        tsel_r <= 1'b1;
        i_r    <= '0;
      end
      OP_RO_LD: begin
        out_data_r  <= rdata;
        out_last_r  <= st.ro_last;
        out_empty_r <= 1'b0;
        out_ovf_r   <= sticky_r;
        i_r         <= i_r + 1'b1;
      end
      OP_RO_EMPTY: begin
        out_data_r  <= '0;
        out_last_r  <= 1'b1;
        out_empty_r <= 1'b1;
        out_ovf_r   <= sticky_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.kind      = kind_r;
    st.is_mac    = kind_r == KIND_MAC;
    st.i_lt_cnt  = i_r < cnt_sel;
    st.ex_gt     = rexp > inse_r;
    st.ex_eq     = rexp == inse_r;
    st.sum_zero  = sum_val == 32'd0;
    st.del_more  = jp1 < cnt_sel;
    st.full      = cnt_sel >= MAX_C;
    st.ins_more  = j_r > i_r;
    st.ins_zero  = insc_r == 32'sd0;
    st.mac_more  = k_r < opcnt_r;
    st.mac_skip  = skip_r;
    st.res_empty = rescnt_r == '0;
    st.out_free  = out_free;
    st.ro_last   = ({1'b0, i_r} + 1'b1 == {1'b0, rescnt_r}) ||
                   ({1'b0, i_r} + 1'b1 == LIM_C);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_empty_r};

endmodule

>>> sv/spalu_ctrl.sv
// Controller state machine of the sparse polynomial ALU.
`timescale 1ns / 1ps
module spalu_ctrl import spalu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t st,
  output dp_op_t     cmd
);

  ctl_state_t state_r, state_nxt, ins_done;

  assign ins_done = st.is_mac ? S_MAC_NEXT : S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_tvalid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        unique case (st.kind)
          KIND_LOAD, KIND_ACC: state_nxt = S_INS_BEGIN;
          KIND_MAC:            state_nxt = S_MAC_TEST;
          KIND_READ:           state_nxt = st.res_empty ? S_RO_EMPTY : S_RO_RD;
          default:             state_nxt = S_IDLE;
        endcase
      end
      S_INS_BEGIN:  state_nxt = st.ins_zero ? ins_done : S_SCAN_TEST;
      S_SCAN_TEST:  state_nxt = st.i_lt_cnt ? S_SCAN_RD : S_PLACE;
      S_SCAN_RD:    state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        priority if (st.ex_gt) state_nxt = S_SCAN_TEST;
        else if (st.ex_eq)     state_nxt = st.sum_zero ? S_DEL_TEST : ins_done;
        else                   state_nxt = S_PLACE;
      end
      S_DEL_TEST:   state_nxt = st.del_more ? S_DEL_RD : ins_done;
      S_DEL_RD:     state_nxt = S_DEL_WR;
      S_DEL_WR:     state_nxt = S_DEL_TEST;
      S_PLACE:      state_nxt = st.full ? ins_done : S_SHIFT_TEST;
      S_SHIFT_TEST: state_nxt = st.ins_more ? S_SHIFT_RD : ins_done;
      S_SHIFT_RD:   state_nxt = S_SHIFT_WR;
      S_SHIFT_WR:   state_nxt = S_SHIFT_TEST;
      S_MAC_TEST:   state_nxt = st.mac_more ? S_MAC_RD : S_IDLE;
      S_MAC_RD:     state_nxt = S_MAC_MUL;
      S_MAC_MUL:    state_nxt = S_MAC_NEG;
      S_MAC_NEG:    state_nxt = S_MAC_RND;
      S_MAC_RND:    state_nxt = S_MAC_CHK;
      S_MAC_CHK:    state_nxt = st.mac_skip ? S_MAC_NEXT : S_INS_BEGIN;
      S_MAC_NEXT:   state_nxt = S_MAC_TEST;
      S_RO_RD:      state_nxt = S_RO_LD;
      S_RO_LD: begin
        if (st.out_free) state_nxt = st.ro_last ? S_IDLE : S_RO_RD;
      end
      S_RO_EMPTY:   if (st.out_free) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = OP_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd = OP_ACCEPT;
      end
      S_DISPATCH: begin
        unique case (st.kind)
          KIND_CLR_RES: cmd = OP_CLR_RES;
          KIND_CLR_OP:  cmd = OP_CLR_OP;
          KIND_LOAD:    cmd = OP_SETUP_LOAD;
          KIND_ACC:     cmd = OP_SETUP_ACC;
          KIND_MAC:     cmd = OP_MAC_INIT;
          KIND_READ:    cmd = st.res_empty ? OP_NONE : OP_RO_INIT;
          default:      cmd = OP_NONE;
        endcase
      end
      S_INS_BEGIN:  cmd = st.ins_zero ? OP_NONE : OP_SCAN_INIT;
      S_SCAN_RD:    cmd = OP_SCAN_RD;
      S_SCAN_CMP: begin
        priority if (st.ex_gt) cmd = OP_SCAN_STEP;
        else if (st.ex_eq)     cmd = OP_MERGE;
        else                   cmd = OP_NONE;
      end
      S_DEL_TEST:   cmd = st.del_more ? OP_NONE : OP_DEL_DONE;
      S_DEL_RD:     cmd = OP_DEL_RD;
      S_DEL_WR:     cmd = OP_DEL_WR;
      S_PLACE:      cmd = st.full ? OP_FULL : OP_INS_INIT;
      S_SHIFT_TEST: cmd = st.ins_more ? OP_NONE : OP_INS_PUT;
      S_SHIFT_RD:   cmd = OP_INS_RD;
      S_SHIFT_WR:   cmd = OP_INS_WR;
      S_MAC_RD:     cmd = OP_MAC_RD;
      S_MAC_MUL:    cmd = OP_MAC_MUL;
      S_MAC_NEG:    cmd = OP_MAC_NEG;
      S_MAC_RND:    cmd = OP_MAC_RND;
      S_MAC_NEXT:   cmd = OP_MAC_NEXT;
      S_RO_LD:      if (st.out_free) cmd = OP_RO_LD;
      S_RO_EMPTY:   if (st.out_free) cmd = OP_RO_EMPTY;
      default:      cmd = OP_NONE;
    endcase
  end

endmodule
